// ----- hdl/gbr_pkg.sv -----
`timescale 1ns / 1ps

package gbr_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_RADIUS  = 3;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_WEIGHT_BITS = 16;

  // Fixed widths of the configuration registers and pixel channels.
  localparam int ROW_BITS    = 13;
  localparam int FW_BITS     = 11;
  localparam int RAD_BITS    = 2;
  localparam int CFG_W_BITS  = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CH_BITS     = 8;
  localparam int PIX_BITS    = 3 * CH_BITS;
  localparam int HW_RADIUS   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_W0     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_W1     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_W2     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_W3     = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DECIDE,
    ST_MUL,
    ST_CMP,
    ST_TAP_INIT,
    ST_TAP_RD,
    ST_TAP_ACC,
    ST_FINISH
  } gbr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic clear_check;
    logic write_adv;
    logic mul;
    logic tap_init;
    logic tap_rd;
    logic tap_acc;
    logic finish;
  } gbr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_drain;
    logic input_done;
    logic emit_ok;
    logic tap_last;
    logic out_free;
  } gbr_stat_t;

endpackage

// ----- hdl/gbr_controller.sv -----
`timescale 1ns / 1ps

module gbr_controller import gbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  gbr_stat_t stat,
  output gbr_cmd_t  cmd
);

  gbr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.clear_check = 1'b1;
        state_next      = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.is_drain) begin
          state_next = stat.input_done ? ST_TAP_INIT : ST_IDLE;
        end else if (stat.input_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.write_adv = 1'b1;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = stat.emit_ok ? ST_TAP_INIT : ST_IDLE;
      end
      ST_TAP_INIT: begin
        cmd.tap_init = 1'b1;
        state_next   = ST_TAP_RD;
      end
      ST_TAP_RD: begin
        cmd.tap_rd = 1'b1;
        state_next = ST_TAP_ACC;
      end
      ST_TAP_ACC: begin
        cmd.tap_acc = 1'b1;
        state_next  = stat.tap_last ? ST_FINISH : ST_TAP_RD;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/gbr_datapath.sv -----
`timescale 1ns / 1ps

module gbr_datapath import gbr_pkg::*; #(
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W_BITS-1:0]   cfg_data,
  input  logic [PIX_BITS-1:0]     s_axis_tdata,
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [PIX_BITS-1:0]     m_axis_tdata,
  output logic                    m_axis_tlast,
  input  gbr_cmd_t                cmd,
  output gbr_stat_t               stat
);

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int SLOT_BITS  = $clog2(STORE_ROWS);
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WID_BITS   = COL_BITS + 1;
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int TAP_BITS   = $clog2(STORE_ROWS);
  localparam int RE_BITS    = (MAX_RADIUS < HW_RADIUS) ? $clog2(MAX_RADIUS + 1) : RAD_BITS;
  localparam int WXY_BITS   = 2 * WEIGHT_BITS;
  localparam int ACC_BITS   = CH_BITS + WXY_BITS + 6;
  localparam int PROD_BITS  = ROW_BITS + 1 + WID_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;

  // Configuration registers.
  logic [FW_BITS-1:0]    frame_width;
  logic [ROW_BITS-1:0]   frame_height;
  logic [RAD_BITS-1:0]   radius_in_use;
  logic [CFG_W_BITS-1:0] weight_reg [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_BITS'(1024);
      frame_height  <= ROW_BITS'(768);
      radius_in_use <= '0;
      weight_reg[0] <= 16'hFFFF;
      weight_reg[1] <= '0;
      weight_reg[2] <= '0;
      weight_reg[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width   <= cfg_data[FW_BITS-1:0];
        REG_HEIGHT: frame_height  <= cfg_data[ROW_BITS-1:0];
        REG_RADIUS: radius_in_use <= cfg_data[RAD_BITS-1:0];
        REG_W0:     weight_reg[0] <= cfg_data;
        REG_W1:     weight_reg[1] <= cfg_data;
        REG_W2:     weight_reg[2] <= cfg_data;
        REG_W3:     weight_reg[3] <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Effective geometry.
  logic [WID_BITS-1:0]  w_eff;
  logic [ROW_BITS-1:0]  h_eff;
  logic [RE_BITS-1:0]   r_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WID_BITS'(1);
    end else if (FW_BITS'(frame_width) > FW_BITS'(MAX_WIDTH) && MAX_WIDTH < 2048) begin
      w_eff = WID_BITS'(MAX_WIDTH);
    end else begin
      w_eff = WID_BITS'(frame_width);
    end
    h_eff = (frame_height == '0) ? ROW_BITS'(1) : frame_height;
    r_eff = (int'(radius_in_use) > MAX_RADIUS) ? RE_BITS'(MAX_RADIUS)
                                               : RE_BITS'(radius_in_use);
  end

  // Item latch.
  logic                is_drain;
  logic [PIX_BITS-1:0] pix;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      is_drain <= s_axis_tuser;
      pix      <= s_axis_tdata;
    end
  end

  // Position counters and row-slot trackers.
  logic [ROW_BITS-1:0]  in_row, out_row;
  logic [COL_BITS-1:0]  in_col, out_col;
  logic [SLOT_BITS-1:0] in_slot, out_slot;

  logic [WID_BITS-1:0]  in_col_inc, out_col_inc;
  logic [ROW_BITS-1:0]  out_row_next;
  logic [COL_BITS-1:0]  out_col_next;
  logic [SLOT_BITS-1:0] out_slot_next;
  logic                 frame_end;

  assign in_col_inc  = WID_BITS'(in_col) + WID_BITS'(1);
  assign out_col_inc = WID_BITS'(out_col) + WID_BITS'(1);

  always_comb begin
    out_row_next  = out_row;
    out_slot_next = out_slot;
    out_col_next  = out_col_inc[COL_BITS-1:0];
    if (out_col_inc >= w_eff) begin
      out_col_next  = '0;
      out_row_next  = out_row + ROW_BITS'(1);
      out_slot_next = (int'(out_slot) == STORE_ROWS - 1) ? '0 : out_slot + SLOT_BITS'(1);
    end
    frame_end = (out_row_next >= h_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0; in_col <= '0; in_slot <= '0;
      out_row <= '0; out_col <= '0; out_slot <= '0;
    end else if (cmd.clear_check) begin
      if (out_row >= h_eff) begin
        in_row <= '0; in_col <= '0; in_slot <= '0;
        out_row <= '0; out_col <= '0; out_slot <= '0;
      end
    end else if (cmd.write_adv) begin
      if (in_col_inc >= w_eff) begin
        in_col  <= '0;
        in_row  <= in_row + ROW_BITS'(1);
        in_slot <= (int'(in_slot) == STORE_ROWS - 1) ? '0 : in_slot + SLOT_BITS'(1);
      end else begin
        in_col <= in_col_inc[COL_BITS-1:0];
      end
    end else if (cmd.finish) begin
      if (frame_end) begin
        in_row <= '0; in_col <= '0; in_slot <= '0;
        out_row <= '0; out_col <= '0; out_slot <= '0;
      end else begin
        out_row  <= out_row_next;
        out_col  <= out_col_next;
        out_slot <= out_slot_next;
      end
    end
  end

  // Lag check: emit when (out_row + r) * w + out_col + r < in_row * w + in_col.
  logic [PROD_BITS-1:0] prod_in, prod_out;
  logic [SUM_BITS-1:0]  lhs, rhs;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_in  <= PROD_BITS'(in_row) * PROD_BITS'(w_eff);
      prod_out <= PROD_BITS'(PROD_BITS'(out_row) + PROD_BITS'(r_eff)) * PROD_BITS'(w_eff);
    end
  end

  assign lhs = SUM_BITS'(prod_out) + SUM_BITS'(out_col) + SUM_BITS'(r_eff);
  assign rhs = SUM_BITS'(prod_in) + SUM_BITS'(in_col);

  // Line store.
  logic [PIX_BITS-1:0]  mem [DEPTH];
  logic [PIX_BITS-1:0]  rdata;
  logic [ADDR_BITS-1:0] wr_addr, rd_addr;

  assign wr_addr = ADDR_BITS'(ADDR_BITS'(in_slot) * ADDR_BITS'(MAX_WIDTH)) + ADDR_BITS'(in_col);

  // Tap walk.
  logic [TAP_BITS-1:0]  ty, tx;
  logic [SLOT_BITS-1:0] tslot;
  logic [ROW_BITS:0]    ysum;
  logic [WID_BITS:0]    xsum;
  logic [ROW_BITS:0]    yy;
  logic [WID_BITS:0]    xx;
  logic                 y_ok, x_ok;
  logic [RE_BITS-1:0]   wy_idx, wx_idx;
  logic [WEIGHT_BITS-1:0] wy, wx;
  logic [WXY_BITS-1:0]  wxy;
  logic                 tap_ok;
  logic [SLOT_BITS:0]   slot_start;
  logic                 ty_last, tx_last;

  assign ysum = (ROW_BITS + 1)'(out_row) + (ROW_BITS + 1)'(ty);
  assign xsum = (WID_BITS + 1)'(out_col) + (WID_BITS + 1)'(tx);
  assign yy   = ysum - (ROW_BITS + 1)'(r_eff);
  assign xx   = xsum - (WID_BITS + 1)'(r_eff);
  assign y_ok = (ysum >= (ROW_BITS + 1)'(r_eff)) && (yy < (ROW_BITS + 1)'(h_eff));
  assign x_ok = (xsum >= (WID_BITS + 1)'(r_eff)) && (xx < (WID_BITS + 1)'(w_eff));
  assign rd_addr = ADDR_BITS'(ADDR_BITS'(tslot) * ADDR_BITS'(MAX_WIDTH))
                 + ADDR_BITS'(xx[COL_BITS-1:0]);

  assign wy_idx = (TAP_BITS'(r_eff) <= ty) ? RE_BITS'(ty - TAP_BITS'(r_eff))
                                          : RE_BITS'(TAP_BITS'(r_eff) - ty);
  assign wx_idx = (TAP_BITS'(r_eff) <= tx) ? RE_BITS'(tx - TAP_BITS'(r_eff))
                                          : RE_BITS'(TAP_BITS'(r_eff) - tx);
  assign wy = WEIGHT_BITS'(weight_reg[wy_idx]);
  assign wx = WEIGHT_BITS'(weight_reg[wx_idx]);

  assign ty_last = (ty == TAP_BITS'(2 * r_eff));
  assign tx_last = (tx == TAP_BITS'(2 * r_eff));
  assign slot_start = (SLOT_BITS + 1)'(out_slot) + (SLOT_BITS + 1)'(STORE_ROWS)
                    - (SLOT_BITS + 1)'(r_eff);

  always_ff @(posedge clk) begin
    if (cmd.write_adv) begin
      mem[wr_addr] <= pix;
    end
    if (cmd.tap_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  logic [ACC_BITS-1:0] acc [3];

  always_ff @(posedge clk) begin
    if (cmd.tap_init) begin
      ty    <= '0;
      tx    <= '0;
      tslot <= (slot_start >= (SLOT_BITS + 1)'(STORE_ROWS))
             ? SLOT_BITS'(slot_start - (SLOT_BITS + 1)'(STORE_ROWS))
             : SLOT_BITS'(slot_start);
      for (int c = 0; c < 3; c++) begin
        acc[c] <= '0;
      end
    end
    if (cmd.tap_rd) begin
      wxy    <= WXY_BITS'(wy) * WXY_BITS'(wx);
      tap_ok <= y_ok && x_ok;
    end
    if (cmd.tap_acc) begin
      for (int c = 0; c < 3; c++) begin
        if (tap_ok) begin
          acc[c] <= acc[c] + ACC_BITS'(ACC_BITS'(rdata[c*CH_BITS +: CH_BITS]) * ACC_BITS'(wxy));
        end
      end
      if (tx_last) begin
        tx    <= '0;
        ty    <= ty + TAP_BITS'(1);
        tslot <= (int'(tslot) == STORE_ROWS - 1) ? '0 : tslot + SLOT_BITS'(1);
      end else begin
        tx <= tx + TAP_BITS'(1);
      end
    end
  end

  // Output register.
  logic [PIX_BITS-1:0] sat;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (acc[c][ACC_BITS-1:WXY_BITS+CH_BITS] != '0) begin
        sat[c*CH_BITS +: CH_BITS] = '1;
      end else begin
        sat[c*CH_BITS +: CH_BITS] = acc[c][WXY_BITS +: CH_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_axis_tdata <= sat;
      m_axis_tlast <= frame_end;
    end
  end

  assign stat.is_drain   = is_drain;
  assign stat.input_done = (in_row >= h_eff);
  assign stat.emit_ok    = (lhs < rhs);
  assign stat.tap_last   = ty_last && tx_last;
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

endmodule

// ----- hdl/gaussian_blur_rgb_stream.sv -----
`timescale 1ns / 1ps
// Items are handled one at a time: a new word is taken only after the last one is done,
// and a word that releases an output first runs the tap walk, which reads one
// line-store word and does one multiply-accumulate per channel for each window tap.
// Reset: synchronous, active high; clears positions, control and registers to defaults.
module gaussian_blur_rgb_stream import gbr_pkg::*; #(
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write port; register index per the register list.
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W_BITS-1:0]   cfg_data,
  // Input words.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [PIX_BITS-1:0]     s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                    s_axis_tuser,  // req_type: 1 is a drain tick
  // Output words.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [PIX_BITS-1:0]     m_axis_tdata,  // out_red, out_green, out_blue
  output logic                    m_axis_tlast   // frame_last
);

  gbr_cmd_t  cmd;
  gbr_stat_t stat;

  // Per word the controller runs a position check, line-store write and lag check
  // (drain: input-done check), then the (2r+1)x(2r+1) window tap walk if output is due.
  gbr_controller u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // The datapath holds the registers, line store, accumulators and the
  // output register, which lets a new word enter while a result waits.
  gbr_datapath #(
    .MAX_RADIUS  (MAX_RADIUS),
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import gbr_pkg::*;

  localparam int STORE_ROWS  = 2 * DEF_MAX_RADIUS + 1;
  localparam int CYCLE_LIMIT = 4000000;
  // Settle time, longer than the worst per-item latency of the block when the output does not stall.
  localparam int SETTLE      = 150;

  typedef struct {
    logic       drain;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_word_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_word_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_W_BITS-1:0]   cfg_data;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [PIX_BITS-1:0]     s_axis_tdata;   // in_red, in_green, in_blue
  logic                    s_axis_tuser;   // req_type
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [PIX_BITS-1:0]     m_axis_tdata;   // out_red, out_green, out_blue
  logic                    m_axis_tlast;   // frame_last

  gaussian_blur_rgb_stream u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Words waiting to be offered and blurred pixels still owed by the block.
  pixel_word_t pending_words[$];
  blur_word_t  owed_pixels[$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  bit word_taken = 0;

  // Blur model state: line store, registers and stream positions.
  logic [23:0] line_mem [0:STORE_ROWS*DEF_MAX_WIDTH-1];
  logic [10:0] reg_width;
  logic [12:0] reg_height;
  logic [1:0]  reg_radius;
  logic [15:0] reg_weight [0:3];
  int unsigned in_row, in_col, out_row, out_col;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned width_now();
    if (reg_width == 0) return 1;
    if (reg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int unsigned height_now();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  // Produce the blurred pixel at the current output position and advance it.
  task automatic emit_blur(input int unsigned w, input int unsigned h,
                           input int unsigned r);
    longint unsigned acc [3];
    longint unsigned wy, wxy;
    logic [23:0] px;
    int yy, xx;
    blur_word_t res;
    acc = '{0, 0, 0};
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      yy = int'(out_row) + dy;
      if (yy < 0 || yy >= int'(h)) continue;
      wy = reg_weight[dy < 0 ? -dy : dy];
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        xx = int'(out_col) + dx;
        if (xx < 0 || xx >= int'(w)) continue;
        wxy = wy * reg_weight[dx < 0 ? -dx : dx];
        px = line_mem[(yy % STORE_ROWS) * DEF_MAX_WIDTH + (xx % DEF_MAX_WIDTH)];
        acc[0] += px[23:16] * wxy;
        acc[1] += px[15:8] * wxy;
        acc[2] += px[7:0] * wxy;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = acc[ch] >> 32;
      if (acc[ch] > 255) acc[ch] = 255;
    end
    res.red = acc[0][7:0];
    res.green = acc[1][7:0];
    res.blue = acc[2][7:0];
    res.last = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      res.last = 1'b1;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
    owed_pixels.push_back(res);
  endtask

  task automatic blur_accept(input pixel_word_t wd);
    int unsigned w, h, r;
    longint unsigned fed, done_lin, lag;
    w = width_now();
    h = height_now();
    r = reg_radius;
    if (out_row >= h) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
    if (!wd.drain) begin
      if (in_row >= h) return;
      line_mem[(in_row % STORE_ROWS) * DEF_MAX_WIDTH + (in_col % DEF_MAX_WIDTH)] =
        {wd.red, wd.green, wd.blue};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      fed = longint'(in_row) * w + in_col;
      done_lin = longint'(out_row) * w + out_col;
      lag = longint'(r) * w + r;
      if (done_lin + lag >= fed) return;
      emit_blur(w, h, r);
    end else if (in_row >= h) begin
      emit_blur(w, h, r);
    end
  endtask

  // Input side: a word that is accepted is handed to the blur model.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      blur_accept('{s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                    s_axis_tdata[23:16]});
      word_taken = 1;
    end
  end

  always @(negedge clk) begin
    pixel_word_t wd;
    if (rst || (s_axis_tvalid && !word_taken)) begin
      // Hold the offered word until it is accepted.
    end else begin
      word_taken = 0;
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        wd = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= wd.drain;
        s_axis_tdata <= {wd.blue, wd.green, wd.red};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: ready is dropped at random and for the long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    blur_word_t exp_px;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (owed_pixels.size() == 0) begin
        $display("%0t: unexpected word rgb=%h last=%b", $time, m_axis_tdata,
                 m_axis_tlast);
        error_count++;
      end else begin
        exp_px = owed_pixels.pop_front();
        if (m_axis_tdata[7:0] !== exp_px.red)
          $display("%0t: red expected %0d actual %0d", $time, exp_px.red,
                   m_axis_tdata[7:0]);
        if (m_axis_tdata[15:8] !== exp_px.green)
          $display("%0t: green expected %0d actual %0d", $time, exp_px.green,
                   m_axis_tdata[15:8]);
        if (m_axis_tdata[23:16] !== exp_px.blue)
          $display("%0t: blue expected %0d actual %0d", $time, exp_px.blue,
                   m_axis_tdata[23:16]);
        if (m_axis_tlast !== exp_px.last)
          $display("%0t: frame_last expected %b actual %b", $time, exp_px.last,
                   m_axis_tlast);
        if (m_axis_tdata !== {exp_px.blue, exp_px.green, exp_px.red} ||
            m_axis_tlast !== exp_px.last)
          error_count++;
      end
    end
  end

  // Register writes happen only while the block is idle, so the model copy
  // is updated at the same moment.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  reg_width = val[10:0];
      REG_HEIGHT: reg_height = val[12:0];
      REG_RADIUS: reg_radius = val[1:0];
      REG_W0:     reg_weight[0] = val[15:0];
      REG_W1:     reg_weight[1] = val[15:0];
      REG_W2:     reg_weight[2] = val[15:0];
      REG_W3:     reg_weight[3] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || s_axis_tvalid || owed_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned r, input bit gauss);
    int unsigned wt [4];
    if (gauss) begin
      // Rough normalized kernels that sum near one in Q0.16.
      wt = '{26000, 15000, 4000, 600};
      for (int i = 0; i < 4; i++) wt[i] = wt[i] + $urandom_range(0, 1500);
    end else begin
      for (int i = 0; i < 4; i++) wt[i] = $urandom_range(0, 65535);
    end
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_W0, wt[0]);
    write_reg(REG_W1, wt[1]);
    write_reg(REG_W2, wt[2]);
    write_reg(REG_W3, wt[3]);
  endtask

  function automatic pixel_word_t rand_pixel();
    pixel_word_t wd;
    wd.drain = 1'b0;
    wd.red = 8'($urandom_range(0, 255));
    wd.green = 8'($urandom_range(0, 255));
    wd.blue = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: begin wd.red = 0; wd.green = 0; wd.blue = 0; end
      1: begin wd.red = 255; wd.green = 255; wd.blue = 255; end
      default: ;
    endcase
    return wd;
  endfunction

  // Queue one full frame under the current registers (when noisy, with an early
  // drain and, at a nonzero radius, an ignored extra pixel), then the drains for the tail.
  task automatic queue_frame(input bit noisy);
    pixel_word_t wd;
    int unsigned w, h, r;
    w = width_now();
    h = height_now();
    r = reg_radius;
    if (noisy) begin
      wd = rand_pixel();
      wd.drain = 1'b1;
      pending_words.push_back(wd);
    end
    for (int i = 0; i < w * h; i++) pending_words.push_back(rand_pixel());
    if (noisy && r > 0) pending_words.push_back(rand_pixel());
    for (int i = 0; i < r * w + r; i++) begin
      wd = rand_pixel();
      wd.drain = 1'b1;
      pending_words.push_back(wd);
    end
  endtask

  initial begin
    int sent;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < STORE_ROWS * DEF_MAX_WIDTH; i++) line_mem[i] = '0;
    reg_width = 11'd1024;
    reg_height = 13'd768;
    reg_radius = 2'd0;
    reg_weight = '{16'd65535, 16'd0, 16'd0, 16'd0};
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: small frames at radius zero, one and three, saturating weights, edges.
    set_geometry(4, 3, 1, 1'b0);
    write_reg(REG_W0, 65535);
    write_reg(REG_W1, 65535);
    queue_frame(1'b1);
    wait_idle();
    set_geometry(3, 2, 3, 1'b1);
    queue_frame(1'b1);
    wait_idle();
    // Width zero acts as one, height zero as one; radius zero has no lag.
    set_geometry(0, 0, 0, 1'b0);
    queue_frame(1'b1);
    wait_idle();
    // Part of a frame, then the height shrinks under it so positions restart.
    set_geometry(2, 4, 0, 1'b0);
    for (int i = 0; i < 3; i++) pending_words.push_back(rand_pixel());
    wait_idle();
    write_reg(REG_HEIGHT, 1);
    queue_frame(1'b0);
    wait_idle();
    // Tall narrow frame: one column, many rows through the line store.
    set_geometry(1, 40, 1, 1'b1);
    queue_frame(1'b0);
    wait_idle();

    // Random frames under four idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 32) : 0;
      recv_stall_pct = (ph == 2) ? 53 : ((ph == 3) ? 32 : 0);
      sent = 0;
      while (sent < 100) begin
        // The first frame of the stall phase gives an output per pixel.
        if (ph == 2 && sent == 0)
          set_geometry(12, 6, 0, 1'b0);
        else
          set_geometry($urandom_range(1, 12), $urandom_range(1, 6),
                       $urandom_range(0, 3), $urandom_range(0, 3) != 0);
        sent += pending_words.size();
        queue_frame($urandom_range(0, 1) == 1);
        sent = pending_words.size() + sent;
        // Long hold-off on the output while input keeps coming.
        if (ph == 2 && hold_cycles == 0 && sent < 100) hold_cycles = 400;
        wait_idle();
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
